[hw/rtl/urmf_pkg.sv]
// Package for the ultrasonic range median filter: state type, cell control
// struct, character codes, register indexes and reset values.
// No dependencies.
package urmf_pkg;

    localparam int RAW_W  = 20;
    localparam int BAND_W = 16;
    localparam int LIM_W  = 6;
    localparam int DIST_W = 28;
    localparam int CFG_W  = 2;
    localparam int DATA_W = 20;

    localparam logic [7:0] CHAR_R  = 8'h52;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;

    localparam logic [RAW_W-1:0] DIGIT_MAX     = 20'hFFFFF;
    localparam logic [RAW_W-1:0] DIGIT_SAT_LIM = 20'd104857;

    localparam logic [CFG_W-1:0] REG_RAW_LOW   = 2'd0;
    localparam logic [CFG_W-1:0] REG_RAW_HIGH  = 2'd1;
    localparam logic [CFG_W-1:0] REG_BAND_HALF = 2'd2;
    localparam logic [CFG_W-1:0] REG_INV_LIMIT = 2'd3;

    localparam logic [RAW_W-1:0]  RST_RAW_LOW   = 20'd500;
    localparam logic [RAW_W-1:0]  RST_RAW_HIGH  = 20'd5000;
    localparam logic [BAND_W-1:0] RST_BAND_HALF = 16'd100;
    localparam logic [LIM_W-1:0]  RST_INV_LIMIT = 6'd30;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MED,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

[hw/rtl/ultrasonic_range_median_filter_unit.sv]
// A byte or timeout is taken while idle; its result, if any, is registered and appears in the next cycle.
// The reading that completes the set starts the finish: S_MED, then the S_SCAN pass, then the registered result.
// Throughput: one transaction per cycle while idle; busy during the finish pass,
// which scans the sorted cell chain one sample per cycle. The receiver cannot stall.
// Reset (synchronous, active low) restores register defaults and clears the sample, invalid and frame counts.
module ultrasonic_range_median_filter_unit
    import urmf_pkg::*;
#(
    parameter int SAMPLES     = 20,
    parameter int FRAME_CHARS = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cmd,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    output logic [DIST_W-1:0] o_distance_q8,
    output logic              o_error,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(SAMPLES + 1);
    localparam int FC_W   = $clog2(FRAME_CHARS + 2);
    localparam int SCAN_W = $clog2(SAMPLES);
    localparam int MID    = SAMPLES / 2;
    localparam bit ODD    = (SAMPLES % 2) == 1;

    logic [RAW_W-1:0]  r_raw_low, r_raw_high;
    logic [BAND_W-1:0] r_band;
    logic [LIM_W-1:0]  r_limit;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LIM_W-1:0]  r_inv, n_inv;
    logic              r_in_frame, n_in_frame;
    logic [FC_W-1:0]   r_fc, n_fc;
    logic [RAW_W-1:0]  r_dv, n_dv;
    logic              r_ended, n_ended;
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic signed [22:0] r_lo2, n_lo2, r_hi2, n_hi2;
    logic [DIST_W-1:0] r_acc, n_acc;
    logic              r_any, n_any;
    logic              r_valid, n_valid;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_err, n_err;

    t_cell_ctl         w_ctl;
    logic [RAW_W-1:0]  w_v [SAMPLES];
    logic              w_gt [SAMPLES];
    logic              w_accept;
    logic              w_inv_ev;
    logic [FC_W-1:0]   w_fc_inc;
    logic              w_is_digit;
    logic [23:0]       w_nv;
    logic [RAW_W-1:0]  w_dv_next;
    logic [20:0]       w_tm;
    logic signed [22:0] w_s2;
    logic              w_in_band;
    logic [DIST_W-1:0] w_s8;
    logic [DIST_W:0]   w_sum;

    assign w_accept = i_start && !o_busy;
    assign o_busy   = r_state != S_IDLE;
    assign o_valid  = r_valid;
    assign o_distance_q8 = r_dist;
    assign o_error  = r_err;

    genvar g;
    generate
        for (g = 0; g < SAMPLES; g++) begin : g_cell
            urmf_cell #(.IDX(g), .CNT_W(CNT_W)) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_cnt    (r_cnt),
                .i_x      (r_dv),
                .i_left_v ((g == 0) ? r_dv : w_v[(g == 0) ? 0 : g - 1]),
                .i_left_gt((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
                .i_right_v((g == SAMPLES - 1) ? w_v[g] : w_v[(g == SAMPLES - 1) ? g : g + 1]),
                .o_v      (w_v[g]),
                .o_gt     (w_gt[g])
            );
        end
    endgenerate

    assign w_fc_inc   = r_fc + 1'b1;
    assign w_is_digit = (i_rx_byte >= CHAR_0) && (i_rx_byte <= CHAR_9);
    assign w_nv       = {1'b0, r_dv, 3'b0} + {3'b0, r_dv, 1'b0} + {20'b0, i_rx_byte[3:0]};
    assign w_dv_next  = (r_dv > DIGIT_SAT_LIM || w_nv > {4'b0, DIGIT_MAX}) ? DIGIT_MAX
                                                                           : w_nv[RAW_W-1:0];

    assign w_tm      = ODD ? {w_v[MID], 1'b0} : ({1'b0, w_v[MID]} + {1'b0, w_v[MID-1]});
    assign w_s2      = $signed({2'b0, w_v[0], 1'b0});
    assign w_in_band = (w_s2 >= r_lo2) && (w_s2 <= r_hi2);
    assign w_s8      = {w_v[0], 8'b0};
    assign w_sum     = {1'b0, r_acc} + {1'b0, w_s8};

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_inv      = r_inv;
        n_in_frame = r_in_frame;
        n_fc       = r_fc;
        n_dv       = r_dv;
        n_ended    = r_ended;
        n_scan     = r_scan;
        n_lo2      = r_lo2;
        n_hi2      = r_hi2;
        n_acc      = r_acc;
        n_any      = r_any;
        n_valid    = 1'b0;
        n_dist     = r_dist;
        n_err      = r_err;
        w_ctl      = '0;
        w_inv_ev   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd) begin
                        n_in_frame = 1'b0; n_fc = '0; n_dv = '0; n_ended = 1'b0;
                        w_inv_ev = 1'b1;
                    end else if (!r_in_frame) begin
                        if (i_rx_byte == CHAR_R) begin
                            n_in_frame = 1'b1; n_fc = '0; n_dv = '0; n_ended = 1'b0;
                        end else begin
                            w_inv_ev = 1'b1;
                        end
                    end else if (w_fc_inc > FC_W'(FRAME_CHARS)) begin
                        n_in_frame = 1'b0; n_fc = '0; n_dv = '0; n_ended = 1'b0;
                        w_inv_ev = 1'b1;
                    end else if (i_rx_byte == CHAR_CR) begin
                        n_in_frame = 1'b0; n_fc = '0; n_dv = '0; n_ended = 1'b0;
                        if (r_dv > r_raw_low && r_dv < r_raw_high) begin
                            w_ctl.ins = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                            if (n_cnt == CNT_W'(SAMPLES)) begin
                                n_state = S_MED;
                            end
                        end else begin
                            w_inv_ev = 1'b1;
                        end
                    end else begin
                        n_fc = w_fc_inc;
                        if (!r_ended) begin
                            if (w_is_digit) begin
                                n_dv = w_dv_next;
                            end else begin
                                n_ended = 1'b1;
                            end
                        end
                    end
                    if (w_inv_ev) begin
                        if (({1'b0, r_inv} + 1'b1) > {1'b0, r_limit}) begin
                            n_valid = 1'b1; n_dist = '0; n_err = 1'b1;
                            n_inv = '0; n_cnt = '0;
                            n_in_frame = 1'b0; n_fc = '0; n_dv = '0; n_ended = 1'b0;
                        end else begin
                            n_inv = r_inv + 1'b1;
                        end
                    end
                end
            end
            S_MED: begin
                n_lo2  = $signed({2'b0, w_tm}) - $signed({6'b0, r_band, 1'b0});
                n_hi2  = $signed({2'b0, w_tm}) + $signed({6'b0, r_band, 1'b0});
                n_scan = '0;
                n_any  = 1'b0;
                n_acc  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_ctl.shift = 1'b1;
                if (w_in_band) begin
                    n_any = 1'b1;
                    n_acc = r_any ? w_sum[DIST_W:1] : w_s8;
                end
                if (r_scan == SCAN_W'(SAMPLES - 1)) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_dist  = n_acc;
                    n_err   = 1'b0;
                    n_cnt   = '0;
                    n_inv   = '0;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_low  <= RST_RAW_LOW;
            r_raw_high <= RST_RAW_HIGH;
            r_band     <= RST_BAND_HALF;
            r_limit    <= RST_INV_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RAW_LOW:   r_raw_low  <= i_cfg_data[RAW_W-1:0];
                REG_RAW_HIGH:  r_raw_high <= i_cfg_data[RAW_W-1:0];
                REG_BAND_HALF: r_band     <= i_cfg_data[BAND_W-1:0];
                REG_INV_LIMIT: r_limit    <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_inv      <= '0;
            r_in_frame <= 1'b0;
            r_fc       <= '0;
            r_dv       <= '0;
            r_ended    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_inv      <= n_inv;
            r_in_frame <= n_in_frame;
            r_fc       <= n_fc;
            r_dv       <= n_dv;
            r_ended    <= n_ended;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_lo2  <= n_lo2;
        r_hi2  <= n_hi2;
        r_acc  <= n_acc;
        r_any  <= n_any;
        r_dist <= n_dist;
        r_err  <= n_err;
    end

`ifndef SYNTH
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(w_accept) || $past(r_state == S_SCAN)))
        else $error("result without a transaction or finish pass");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_distance_q8 == '0))
        else $error("error result carries a distance");
    a_med_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MED) |-> (r_cnt == CNT_W'(SAMPLES)))
        else $error("finish started without a full sample set");
`endif

endmodule

[hw/rtl/urmf_cell.sv]
// One cell of the sorted sample chain: insertion in place or shift toward cell 0.
// Depends on urmf_pkg.
module urmf_cell
    import urmf_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic [RAW_W-1:0] i_x,
    input  logic [RAW_W-1:0] i_left_v,
    input  logic             i_left_gt,
    input  logic [RAW_W-1:0] i_right_v,
    output logic [RAW_W-1:0] o_v,
    output logic             o_gt
);

    logic [RAW_W-1:0] r_v;
    logic [RAW_W-1:0] n_v;
    logic             w_used;
    logic             w_tail;

    assign w_used = CNT_W'(IDX) < i_cnt;
    assign w_tail = CNT_W'(IDX) == i_cnt;
    assign o_gt   = w_used && (r_v > i_x);
    assign o_v    = r_v;

    always_comb begin
        n_v = r_v;
        if (i_ctl.shift) begin
            n_v = i_right_v;
        end else if (i_ctl.ins && (o_gt || w_tail)) begin
            n_v = i_left_gt ? i_left_v : i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

endmodule

[dv/ultrasonic_range_median_filter_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the ultrasonic range median filter: tracks register writes, predicts
// the filtered distance or error from the accepted transactions and compares results.
// Depends on urmf_pkg.
module ultrasonic_range_median_filter_unit_checker
    import urmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_valid,
    input  logic [DIST_W-1:0] i_distance_q8,
    input  logic              i_error,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int N_SAMPLES   = 20;
    localparam int FRAME_LIMIT = 7;

    typedef struct packed {
        logic [DIST_W-1:0] distance_q8;
        logic              error;
    } t_range_result;

    logic [RAW_W-1:0]  raw_low, raw_high;
    logic [BAND_W-1:0] band_half;
    logic [LIM_W-1:0]  invalid_limit;

    logic [RAW_W-1:0] readings [N_SAMPLES];
    int               reading_count;
    int               invalid_count;
    logic             in_frame;
    int               frame_chars;
    logic [RAW_W-1:0] digit_value;
    logic             digits_ended;

    t_range_result expected_ranges [$];

    function automatic logic [DIST_W-1:0] median_gated_average();
        logic [RAW_W-1:0] v [N_SAMPLES];
        logic [RAW_W-1:0] key;
        longint           twice_med, lo2, hi2, s2;
        longint unsigned  acc;
        logic             any;
        int               j;
        for (int i = 0; i < N_SAMPLES; i++) v[i] = readings[i];
        for (int i = 1; i < N_SAMPLES; i++) begin
            key = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > key) begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = key;
        end
        if (N_SAMPLES % 2 == 0) begin
            twice_med = longint'(v[N_SAMPLES / 2]) + longint'(v[N_SAMPLES / 2 - 1]);
        end else begin
            twice_med = 2 * longint'(v[N_SAMPLES / 2]);
        end
        lo2 = twice_med - 2 * longint'(band_half);
        hi2 = twice_med + 2 * longint'(band_half);
        acc = 0;
        any = 1'b0;
        for (int i = 0; i < N_SAMPLES; i++) begin
            s2 = 2 * longint'(v[i]);
            if (s2 >= lo2 && s2 <= hi2) begin
                if (!any) begin
                    acc = longint'(v[i]) << 8;
                    any = 1'b1;
                end else begin
                    acc = (acc + (longint'(v[i]) << 8)) >> 1;
                end
            end
        end
        return acc[DIST_W-1:0];
    endfunction

    task automatic drop_frame();
        in_frame = 1'b0;
        frame_chars = 0;
        digit_value = '0;
        digits_ended = 1'b0;
    endtask

    task automatic clear_measurement();
        reading_count = 0;
        invalid_count = 0;
        drop_frame();
    endtask

    task automatic count_invalid();
        t_range_result r;
        if (invalid_count + 1 > int'(invalid_limit)) begin
            r.distance_q8 = '0;
            r.error = 1'b1;
            expected_ranges.push_back(r);
            clear_measurement();
        end else begin
            invalid_count++;
        end
    endtask

    task automatic parse_event(input logic cmd, input logic [7:0] b);
        t_range_result    r;
        logic [RAW_W-1:0] val;
        int unsigned      nv;
        if (cmd) begin
            drop_frame();
            count_invalid();
        end else if (!in_frame) begin
            if (b == CHAR_R) begin
                drop_frame();
                in_frame = 1'b1;
            end else begin
                count_invalid();
            end
        end else begin
            frame_chars++;
            if (frame_chars > FRAME_LIMIT) begin
                drop_frame();
                count_invalid();
            end else if (b == CHAR_CR) begin
                val = digit_value;
                drop_frame();
                if (val > raw_low && val < raw_high && reading_count < N_SAMPLES) begin
                    readings[reading_count] = val;
                    reading_count++;
                    if (reading_count >= N_SAMPLES) begin
                        r.distance_q8 = median_gated_average();
                        r.error = 1'b0;
                        expected_ranges.push_back(r);
                        clear_measurement();
                    end
                end else begin
                    count_invalid();
                end
            end else if (!digits_ended) begin
                if (b >= CHAR_0 && b <= CHAR_9) begin
                    nv = int'(digit_value) * 10 + int'(b - CHAR_0);
                    if (digit_value > DIGIT_SAT_LIM || nv > int'(DIGIT_MAX)) begin
                        digit_value = DIGIT_MAX;
                    end else begin
                        digit_value = nv[RAW_W-1:0];
                    end
                end else begin
                    digits_ended = 1'b1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_range_result exp_r;
        if (!i_rst_n) begin
            raw_low = RST_RAW_LOW;
            raw_high = RST_RAW_HIGH;
            band_half = RST_BAND_HALF;
            invalid_limit = RST_INV_LIMIT;
            clear_measurement();
            expected_ranges.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid) begin
                if (expected_ranges.size() == 0) begin
                    $display("%0t: unexpected result distance_q8=%0d error=%0d",
                             $time, i_distance_q8, i_error);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_ranges.pop_front();
                    if (i_distance_q8 !== exp_r.distance_q8 || i_error !== exp_r.error) begin
                        $display("%0t: mismatch expected distance_q8=%0d error=%0d, actual distance_q8=%0d error=%0d",
                                 $time, exp_r.distance_q8, exp_r.error, i_distance_q8, i_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) parse_event(i_cmd, i_rx_byte);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RAW_LOW:   raw_low = i_cfg_data[RAW_W-1:0];
                    REG_RAW_HIGH:  raw_high = i_cfg_data[RAW_W-1:0];
                    REG_BAND_HALF: band_half = i_cfg_data[BAND_W-1:0];
                    REG_INV_LIMIT: invalid_limit = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_ranges.size();
    end

endmodule

[dv/ultrasonic_range_median_filter_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the ultrasonic range median filter testbench: clock, reset, register
// phases and frame stimulus. Depends on urmf_pkg, the block and its checker.
module ultrasonic_range_median_filter_unit_tb;
    import urmf_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 40;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic              i_cmd;
    logic [7:0]        i_rx_byte;
    logic              o_valid;
    logic [DIST_W-1:0] o_distance_q8;
    logic              o_error;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;
    int                fail_count;
    int                pending;

    int bytes_sent;
    int ranges_seen;
    int idle_cycles;
    int cur_low, cur_high;

    ultrasonic_range_median_filter_unit uut (.*);

    ultrasonic_range_median_filter_unit_checker range_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_cmd, .i_rx_byte,
        .i_valid(o_valid), .i_distance_q8(o_distance_q8), .i_error(o_error),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && o_valid) ranges_seen <= ranges_seen + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired", $time);
            $display("** ultrasonic_range_median_filter_unit: FAILED **");
            $finish;
        end
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_event(input logic cmd, input logic [7:0] b);
        int gap;
        i_start <= 1'b1;
        i_cmd <= cmd;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_busy);
        bytes_sent++;
        @(negedge i_clk);
        gap = random_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            i_cmd <= $urandom_range(0, 1);
            i_rx_byte <= $urandom_range(0, 255);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_event(1'b0, s[i]);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[DATA_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned lo, input int unsigned hi,
                             input int unsigned band, input int unsigned lim);
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(REG_RAW_LOW, lo);
        write_reg(REG_RAW_HIGH, hi);
        write_reg(REG_BAND_HALF, band);
        write_reg(REG_INV_LIMIT, lim);
        i_cfg_we <= 1'b0;
        cur_low = lo;
        cur_high = hi;
    endtask

    task automatic random_transaction_group(input int base);
        int r, v;
        string s;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            v = base + $urandom_range(0, 300) - 150;
            if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1048575);
            if (v < 0) v = 0;
            s = $sformatf("R%0d", v);
            if ($urandom_range(0, 19) == 0) s = {"R0", s.substr(1, s.len() - 1)};
            if ($urandom_range(0, 19) == 0) s = {s, "x"};
            send_text({s, "\r"});
        end else if (r < 88) begin
            send_event(1'b0, $urandom_range(0, 255));
        end else if (r < 92) begin
            send_event(1'b1, $urandom_range(0, 255));
        end else begin
            s = $sformatf("R%0d", $urandom_range(0, 99999));
            send_text(s.substr(0, $urandom_range(0, s.len() - 1)));
            if ($urandom_range(0, 1)) send_event(1'b1, 8'h00);
        end
    endtask

    task automatic random_phase(input int target, input int want_ranges);
        int base;
        base = 0;
        while (bytes_sent < target || ranges_seen < want_ranges) begin
            if (base == 0 || $urandom_range(0, 39) == 0) begin
                if (cur_high > cur_low + 2) begin
                    base = $urandom_range(cur_low + 1, cur_high - 1);
                end else begin
                    base = $urandom_range(1, 1048575);
                end
            end
            random_transaction_group(base);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = 1'b0;
        i_rx_byte = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        bytes_sent = 0;
        ranges_seen = 0;
        idle_cycles = 0;
        cur_low = 500;
        cur_high = 5000;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed frames: in range, overlong, saturated, signed, blank, ended digits, noise, a command event.
        send_text("R1000\r");
        send_text("R12345678");
        send_text("R9999999\r");
        send_text("R-5\r");
        send_event(1'b0, 8'hFF);
        send_text("R12a3\r");
        send_event(1'b1, 8'h00);
        send_text("R 7\r");

        configure(500, 5000, 100, 30);
        random_phase(600, 0);
        configure(0, 999999, 0, 0);
        random_phase(1000, 0);
        configure(999999, 0, 65535, 63);
        random_phase(1200, 0);
        configure(1000, 1100, 65535, 63);
        random_phase(1600, 0);
        configure(200, 9000, 50, 20);
        random_phase(2000, 0);

        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** ultrasonic_range_median_filter_unit: PASSED **");
        end else begin
            $display("** ultrasonic_range_median_filter_unit: FAILED **");
        end
        $finish;
    end

endmodule
